// File: rtl/gfp_pkg.sv
// Package: shared types, field widths and constants of the 4bpp framebuffer packer.
package gfp_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int STORE_BYTES = (MAX_WIDTH * MAX_HEIGHT) / 2;
    localparam int ADDR_W      = $clog2(STORE_BYTES);

    localparam int X_W      = 10;
    localparam int Y_W      = 10;
    localparam int GRAY_W   = 8;
    localparam int NIB_W    = 4;
    localparam int BADDR_W  = 19;
    localparam int BYTE_W   = 8;
    localparam int DW_W     = 11;
    localparam int SIZE_W   = 11;
    localparam int PROD_W   = Y_W + DW_W;

    localparam logic [DW_W-1:0]  DW_RESET    = DW_W'(960);
    localparam logic [X_W-1:0]   BOX_MIN_X0  = '1;
    localparam logic [Y_W-1:0]   BOX_MIN_Y0  = '1;
    localparam logic [NIB_W-1:0] NIB_WHITE   = '1;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_READ  = 1'b1
    } req_type_t;

    typedef enum logic {
        KIND_READ = 1'b0,
        KIND_RECT = 1'b1
    } result_kind_t;

    typedef struct packed {
        logic              en;
        logic              lo_en;
        logic              hi_en;
        logic [ADDR_W-1:0] addr;
        logic [NIB_W-1:0]  nib;
    } ram_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } ram_rd_t;

endpackage

// File: rtl/gfp_if.sv
// Interfaces: request and result channels with valid/ready handshake.
interface gfp_req_if;
    import gfp_pkg::*;

    logic               valid;
    logic               ready;
    logic               req_type;
    logic [X_W-1:0]     pixel_x;
    logic [Y_W-1:0]     pixel_y;
    logic [GRAY_W-1:0]  gray_level;
    logic               end_of_update;
    logic [BADDR_W-1:0] byte_address;

    modport source (
        output valid, req_type, pixel_x, pixel_y, gray_level, end_of_update, byte_address,
        input  ready
    );
    modport sink (
        input  valid, req_type, pixel_x, pixel_y, gray_level, end_of_update, byte_address,
        output ready
    );
endinterface

interface gfp_rsp_if;
    import gfp_pkg::*;

    logic              valid;
    logic              ready;
    logic              result_kind;
    logic [BYTE_W-1:0] read_byte;
    logic [X_W-1:0]    rect_x;
    logic [Y_W-1:0]    rect_y;
    logic [SIZE_W-1:0] rect_width;
    logic [SIZE_W-1:0] rect_height;

    modport source (
        output valid, result_kind, read_byte, rect_x, rect_y, rect_width, rect_height,
        input  ready
    );
    modport sink (
        input  valid, result_kind, read_byte, rect_x, rect_y, rect_width, rect_height,
        output ready
    );
endinterface

// File: rtl/gray8_to_4bpp_framebuffer_packer_top.sv
// Top level: 4bpp framebuffer packer with dirty rectangle tracking.
//
// The request channel carries pixel writes and framebuffer byte reads. A write
// stores the upper four bits of gray_level into the byte at
// (pixel_y * display_width) / 2 + pixel_x / 2, odd columns in the high nibble,
// and grows the dirty box; a write with end_of_update returns the box on the
// result channel and restarts it. A read returns one stored byte.
// One item is taken every cycle while the receiver does not stall. A result
// passes the input register, the multiply register, then the RAM read and
// result register. Plain writes give no result.
// display_width is written through cfg_wr_en/cfg_wr_data while idle.
// After reset the frame store is swept to white, one byte a cycle, over all
// 524288 bytes; request.ready stays low during the sweep.
// When the receiver stalls, the whole pipeline holds and request.ready
// drops in the same cycle; no item is lost.
module gray8_to_4bpp_framebuffer_packer_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [gfp_pkg::DW_W-1:0]    cfg_wr_data,
    gfp_req_if.sink                     request,
    gfp_rsp_if.source                   result
);
    import gfp_pkg::*;

    logic [DW_W-1:0]   dw_reg;
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    logic              adv;
    logic              accept;

    logic              s1_valid_reg;
    req_type_t         s1_req_reg;
    logic [X_W-1:0]    s1_x_reg;
    logic [Y_W-1:0]    s1_y_reg;
    logic [NIB_W-1:0]  s1_nib_reg;
    logic              s1_eou_reg;
    logic [BADDR_W-1:0] s1_baddr_reg;

    logic [X_W-1:0]    box_min_x_reg;
    logic [Y_W-1:0]    box_min_y_reg;
    logic [X_W-1:0]    box_max_x_reg;
    logic [Y_W-1:0]    box_max_y_reg;
    logic [X_W-1:0]    box_min_x_next;
    logic [Y_W-1:0]    box_min_y_next;
    logic [X_W-1:0]    box_max_x_next;
    logic [Y_W-1:0]    box_max_y_next;
    logic              s1_emit;

    logic              s2_valid_reg;
    req_type_t         s2_req_reg;
    logic              s2_eou_reg;
    logic [PROD_W-1:0] s2_prod_reg;
    logic [X_W-1:0]    s2_x_reg;
    logic [NIB_W-1:0]  s2_nib_reg;
    logic [BADDR_W-1:0] s2_baddr_reg;
    logic [X_W-1:0]    s2_rect_x_reg;
    logic [Y_W-1:0]    s2_rect_y_reg;
    logic [SIZE_W-1:0] s2_rect_w_reg;
    logic [SIZE_W-1:0] s2_rect_h_reg;
    logic [PROD_W-1:0] s2_addr_sum;

    logic              out_valid_reg;
    result_kind_t      out_kind_reg;
    logic [X_W-1:0]    out_rect_x_reg;
    logic [Y_W-1:0]    out_rect_y_reg;
    logic [SIZE_W-1:0] out_rect_w_reg;
    logic [SIZE_W-1:0] out_rect_h_reg;

    ram_wr_t           ram_wr;
    ram_rd_t           ram_rd;
    logic [BYTE_W-1:0] ram_rd_data;

    assign adv           = !out_valid_reg || result.ready;
    assign request.ready = adv && !clearing_reg;
    assign accept        = request.valid && request.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dw_reg <= DW_RESET;
        end
        else if (cfg_wr_en)
        begin
            dw_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == '1)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // stage 1: input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg   <= req_type_t'(request.req_type);
            s1_x_reg     <= request.pixel_x;
            s1_y_reg     <= request.pixel_y;
            s1_nib_reg   <= request.gray_level[GRAY_W-1 -: NIB_W];
            s1_eou_reg   <= request.end_of_update;
            s1_baddr_reg <= request.byte_address;
        end
    end

    always_comb
    begin
        box_min_x_next = (s1_x_reg < box_min_x_reg) ? s1_x_reg : box_min_x_reg;
        box_min_y_next = (s1_y_reg < box_min_y_reg) ? s1_y_reg : box_min_y_reg;
        box_max_x_next = (s1_x_reg > box_max_x_reg) ? s1_x_reg : box_max_x_reg;
        box_max_y_next = (s1_y_reg > box_max_y_reg) ? s1_y_reg : box_max_y_reg;
        s1_emit        = (s1_req_reg == REQ_WRITE) && s1_eou_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_min_x_reg <= BOX_MIN_X0;
            box_min_y_reg <= BOX_MIN_Y0;
            box_max_x_reg <= '0;
            box_max_y_reg <= '0;
        end
        else if (adv && s1_valid_reg && (s1_req_reg == REQ_WRITE))
        begin
            if (s1_eou_reg)
            begin
                box_min_x_reg <= BOX_MIN_X0;
                box_min_y_reg <= BOX_MIN_Y0;
                box_max_x_reg <= '0;
                box_max_y_reg <= '0;
            end
            else
            begin
                box_min_x_reg <= box_min_x_next;
                box_min_y_reg <= box_min_y_next;
                box_max_x_reg <= box_max_x_next;
                box_max_y_reg <= box_max_y_next;
            end
        end
    end

    // stage 2: row offset product and box snapshot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_req_reg   <= s1_req_reg;
            s2_eou_reg   <= s1_eou_reg;
            s2_prod_reg  <= PROD_W'(s1_y_reg) * PROD_W'(dw_reg);
            s2_x_reg     <= s1_x_reg;
            s2_nib_reg   <= s1_nib_reg;
            s2_baddr_reg <= s1_baddr_reg;
            if (s1_emit)
            begin
                s2_rect_x_reg <= box_min_x_next;
                s2_rect_y_reg <= box_min_y_next;
                s2_rect_w_reg <= SIZE_W'(box_max_x_next) - SIZE_W'(box_min_x_next) + 1'b1;
                s2_rect_h_reg <= SIZE_W'(box_max_y_next) - SIZE_W'(box_min_y_next) + 1'b1;
            end
            else
            begin
                s2_rect_x_reg <= '0;
                s2_rect_y_reg <= '0;
                s2_rect_w_reg <= '0;
                s2_rect_h_reg <= '0;
            end
        end
    end

    assign s2_addr_sum = (s2_prod_reg >> 1) + PROD_W'(s2_x_reg[X_W-1:1]);

    always_comb
    begin
        if (clearing_reg)
        begin
            ram_wr.en    = 1'b1;
            ram_wr.lo_en = 1'b1;
            ram_wr.hi_en = 1'b1;
            ram_wr.addr  = clr_addr_reg;
            ram_wr.nib   = NIB_WHITE;
        end
        else
        begin
            ram_wr.en    = adv && s2_valid_reg && (s2_req_reg == REQ_WRITE);
            ram_wr.lo_en = !s2_x_reg[0];
            ram_wr.hi_en = s2_x_reg[0];
            ram_wr.addr  = s2_addr_sum[ADDR_W-1:0];
            ram_wr.nib   = s2_nib_reg;
        end
        ram_rd.en   = adv;
        ram_rd.addr = s2_baddr_reg[ADDR_W-1:0];
    end

    gfp_nibble_ram u_store (
        .clk     (clk),
        .wr      (ram_wr),
        .rd      (ram_rd),
        .rd_data (ram_rd_data)
    );

    // stage 3: result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s2_valid_reg && ((s2_req_reg == REQ_READ) || s2_eou_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_kind_reg   <= (s2_req_reg == REQ_READ) ? KIND_READ : KIND_RECT;
            out_rect_x_reg <= s2_rect_x_reg;
            out_rect_y_reg <= s2_rect_y_reg;
            out_rect_w_reg <= s2_rect_w_reg;
            out_rect_h_reg <= s2_rect_h_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.result_kind = out_kind_reg;
    assign result.read_byte   = (out_kind_reg == KIND_READ) ? ram_rd_data : '0;
    assign result.rect_x      = out_rect_x_reg;
    assign result.rect_y      = out_rect_y_reg;
    assign result.rect_width  = out_rect_w_reg;
    assign result.rect_height = out_rect_h_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !request.ready)
    else $error("item accepted during frame store sweep");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clearing_reg) |-> (clr_addr_reg == '0))
    else $error("frame store sweep ended before covering every byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.result_kind == KIND_RECT))
            |-> ((result.rect_width != '0) && (result.rect_height != '0)
                 && (result.read_byte == '0)))
    else $error("malformed update rectangle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (clearing_reg || (ram_wr.en && !clearing_reg))
            |-> (ram_wr.lo_en || ram_wr.hi_en))
    else $error("store write with no nibble selected");

endmodule

// File: rtl/gfp_nibble_ram.sv
// Frame store: byte RAM split into low and high nibble arrays with registered read.
module gfp_nibble_ram (
    input  logic                          clk,
    input  gfp_pkg::ram_wr_t              wr,
    input  gfp_pkg::ram_rd_t              rd,
    output logic [gfp_pkg::BYTE_W-1:0]    rd_data
);
    import gfp_pkg::*;

    logic [NIB_W-1:0] lo_mem [STORE_BYTES];
    logic [NIB_W-1:0] hi_mem [STORE_BYTES];
    logic [NIB_W-1:0] lo_rd_reg;
    logic [NIB_W-1:0] hi_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en && wr.lo_en)
        begin
            lo_mem[wr.addr] <= wr.nib;
        end
        if (rd.en)
        begin
            lo_rd_reg <= lo_mem[rd.addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && wr.hi_en)
        begin
            hi_mem[wr.addr] <= wr.nib;
        end
        if (rd.en)
        begin
            hi_rd_reg <= hi_mem[rd.addr];
        end
    end

    assign rd_data = {hi_rd_reg, lo_rd_reg};

endmodule
